// File: src/lz77bd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ77 backward bit decoder package
// Shared beat types, opcode and status codes, and sizing constants.
// ----------------------------------------------------------------------------
package lz77bd_pkg;

    localparam int HIST_AW     = 14;
    localparam int MAX_OUTPUT  = 131072;
    localparam int LEN_W       = 18;
    localparam int POS_W       = 17;

    localparam logic [1:0] OP_WORD = 2'd0;
    localparam logic [1:0] OP_STEP = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    localparam logic [2:0] ST_WORD    = 3'd0;
    localparam logic [2:0] ST_BYTE    = 3'd1;
    localparam logic [2:0] ST_NEED    = 3'd2;
    localparam logic [2:0] ST_DONE    = 3'd3;
    localparam logic [2:0] ST_CHKSUM  = 3'd4;
    localparam logic [2:0] ST_INPUT   = 3'd5;
    localparam logic [2:0] ST_OVERRUN = 3'd6;
    localparam logic [2:0] ST_DIST    = 3'd7;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] word;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       data_byte;
        logic [POS_W-1:0] position;
        logic             last;
    } t_out_beat;

endpackage

// File: src/lz77_backward_bit_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ77 backward bit decoder core
// Decodes a backward LSB-first bitstream of literal runs and matches.
// ----------------------------------------------------------------------------
// A word beat or a header reply is answered straight from S_RUN; a step beat
// consumes stream bits one by one until it emits a byte, asks for a word or ends,
// and a match copy goes on through S_COPY; the result is registered.
// The core takes one beat at a time and accepts a new one only in S_IDLE.
// Reset (synchronous, active low) clears all control state; the history
// memory is not cleared and needs no clearing pass.
module lz77_backward_bit_decoder_core
    import lz77bd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    // Control sequencer: wait for a beat, run the bit loop, finish a copy.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_COPY = 3'b100
    } t_state;

    // Header progress: length word, checksum seed, data words, finished.
    typedef enum logic [3:0] {
        H_LEN  = 4'b0001,
        H_SEED = 4'b0010,
        H_DATA = 4'b0100,
        H_DONE = 4'b1000
    } t_hdr;

    // Token parser phases.
    typedef enum logic [15:0] {
        T_SKIP  = 16'h0001,
        T_LSEL  = 16'h0002,
        T_LEXT  = 16'h0004,
        T_L4    = 16'h0008,
        T_LEXT2 = 16'h0010,
        T_L8    = 16'h0020,
        T_LIT   = 16'h0040,
        T_MSEL  = 16'h0080,
        T_MEXT  = 16'h0100,
        T_M4    = 16'h0200,
        T_MEXT2 = 16'h0400,
        T_M8    = 16'h0800,
        T_DSEL  = 16'h1000,
        T_D8    = 16'h2000,
        T_D13   = 16'h4000,
        T_COPY  = 16'h8000
    } t_tok;

    t_state           r_state, n_state;
    t_hdr             r_hdr, n_hdr;
    t_tok             r_tok, n_tok;
    logic [1:0]       r_op, n_op;
    logic [31:0]      r_word, n_word;
    logic [31:0]      r_buf, n_buf;
    logic [4:0]       r_bits_left, n_bits_left;
    logic             r_buf_full, n_buf_full;
    logic [31:0]      r_chk, n_chk;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic [LEN_W-1:0] r_len, n_len;
    logic [12:0]      r_acc, n_acc;
    logic [3:0]       r_fbn, n_fbn;
    logic [8:0]       r_run, n_run;
    logic [13:0]      r_dist, n_dist;
    logic [2:0]       r_final, n_final;
    logic             r_out_valid, n_out_valid;
    t_out_beat        r_out, n_out;

    // History memory: one write port and one registered read port.
    logic [7:0]         r_hist [0:(1 << HIST_AW)-1];
    logic [7:0]         r_rd;
    logic               mem_we;
    logic [HIST_AW-1:0] mem_wa;
    logic [7:0]         mem_wd;
    logic [HIST_AW-1:0] mem_ra;

    logic in_acc;
    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        logic             emit;
        logic             fin;
        logic [2:0]       e_st;
        logic [7:0]       e_b;
        logic [POS_W-1:0] e_pos;
        logic [3:0]       nbits;
        logic [3:0]       need;
        logic [3:0]       need2;
        logic [12:0]      acc;
        logic [12:0]      v;
        logic [LEN_W-1:0] q;
        logic [LEN_W-1:0] src;
        logic [8:0]       run2;

        n_state     = r_state;
        n_hdr       = r_hdr;
        n_tok       = r_tok;
        n_op        = r_op;
        n_word      = r_word;
        n_buf       = r_buf;
        n_bits_left = r_bits_left;
        n_buf_full  = r_buf_full;
        n_chk       = r_chk;
        n_rem       = r_rem;
        n_len       = r_len;
        n_acc       = r_acc;
        n_fbn       = r_fbn;
        n_run       = r_run;
        n_dist      = r_dist;
        n_final     = r_final;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;

        emit  = 1'b0;
        fin   = 1'b0;
        e_st  = ST_WORD;
        e_b   = 8'd0;
        e_pos = '0;
        q     = r_rem - LEN_W'(1);
        src   = q + LEN_W'(r_dist);
        run2  = r_run - 9'd1;
        acc   = 13'd0;
        v     = 13'd0;
        need  = 4'd0;
        need2 = 4'd0;

        mem_we = 1'b0;
        mem_wa = q[HIST_AW-1:0];
        mem_wd = 8'd0;
        mem_ra = src[HIST_AW-1:0];

        case (r_tok)
            T_LSEL, T_MSEL:              nbits = 4'd2;
            T_L4, T_M4:                  nbits = 4'd4;
            T_L8, T_M8, T_LIT, T_D8:     nbits = 4'd8;
            T_D13:                       nbits = 4'd13;
            default:                     nbits = 4'd1;
        endcase

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op    = i_data.op;
                    n_word  = i_data.word;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_hdr == H_DONE) begin
                    emit = 1'b1;
                    e_st = r_final;
                end else if (r_op == OP_WORD) begin
                    emit = 1'b1;
                    e_st = ST_WORD;
                    case (r_hdr)
                        H_LEN: begin
                            if (r_word > 32'(MAX_OUTPUT)) begin
                                fin  = 1'b1;
                                e_st = ST_OVERRUN;
                            end else begin
                                n_rem = r_word[LEN_W-1:0];
                                n_len = r_word[LEN_W-1:0];
                                n_hdr = H_SEED;
                            end
                        end
                        H_SEED: begin
                            n_chk = r_word;
                            n_hdr = H_DATA;
                        end
                        default: begin
                            if (!r_buf_full) begin
                                n_buf       = r_word;
                                n_chk       = r_chk ^ r_word;
                                n_bits_left = 5'd31;
                                n_buf_full  = 1'b1;
                            end
                        end
                    endcase
                end else if (r_hdr != H_DATA) begin
                    emit = 1'b1;
                    fin  = (r_op == OP_END);
                    e_st = (r_op == OP_END) ? ST_INPUT : ST_NEED;
                end else if (r_tok == T_LSEL && r_rem == '0) begin
                    fin  = 1'b1;
                    e_st = (r_chk != 32'd0) ? ST_CHKSUM : ST_DONE;
                end else if (r_tok == T_COPY) begin
                    if (r_rem == '0) begin
                        fin  = 1'b1;
                        e_st = ST_OVERRUN;
                    end else if (src >= r_len) begin
                        fin  = 1'b1;
                        e_st = ST_DIST;
                    end else begin
                        n_state = S_COPY;
                    end
                end else begin
                    need = (r_fbn == 4'd0) ? nbits : r_fbn;
                    acc  = (r_fbn == 4'd0) ? 13'd0 : r_acc;
                    if (!r_buf_full) begin
                        n_fbn = need;
                        n_acc = acc;
                        emit  = 1'b1;
                        fin   = (r_op == OP_END);
                        e_st  = (r_op == OP_END) ? ST_INPUT : ST_NEED;
                    end else begin
                        v     = {acc[11:0], r_buf[0]};
                        need2 = need - 4'd1;
                        n_acc = v;
                        n_fbn = need2;
                        n_buf = {1'b0, r_buf[31:1]};
                        if (r_bits_left == 5'd0) begin
                            n_buf_full = 1'b0;
                        end else begin
                            n_bits_left = r_bits_left - 5'd1;
                        end
                        if (need2 == 4'd0) begin
                            case (r_tok)
                                T_SKIP: begin
                                    if (v != 13'd0) n_tok = T_LSEL;
                                end
                                T_LSEL: begin
                                    if (v < 13'd3) begin
                                        n_run = 9'(v) + 9'd1;
                                        n_tok = T_LIT;
                                    end else begin
                                        n_tok = T_LEXT;
                                    end
                                end
                                T_LEXT:  n_tok = (v != 13'd0) ? T_LEXT2 : T_L4;
                                T_L4: begin
                                    n_run = 9'(v) + 9'd4;
                                    n_tok = T_LIT;
                                end
                                T_LEXT2: n_tok = (v != 13'd0) ? T_MSEL : T_L8;
                                T_L8: begin
                                    n_run = 9'(v) + 9'd20;
                                    n_tok = T_LIT;
                                end
                                T_LIT: begin
                                    if (r_rem == '0) begin
                                        fin  = 1'b1;
                                        e_st = ST_OVERRUN;
                                    end else begin
                                        mem_we = 1'b1;
                                        mem_wd = v[7:0];
                                        n_rem  = q;
                                        n_run  = run2;
                                        if (run2 == 9'd0) begin
                                            n_tok = (q == '0) ? T_LSEL : T_MSEL;
                                        end
                                        emit  = 1'b1;
                                        e_st  = ST_BYTE;
                                        e_b   = v[7:0];
                                        e_pos = q[POS_W-1:0];
                                    end
                                end
                                T_MSEL: begin
                                    if (v == 13'd3) begin
                                        n_tok = T_MEXT;
                                    end else if (v == 13'd0) begin
                                        n_run = 9'd2;
                                        n_tok = T_D8;
                                    end else begin
                                        n_run = 9'(v) + 9'd2;
                                        n_tok = T_DSEL;
                                    end
                                end
                                T_MEXT:  n_tok = (v != 13'd0) ? T_MEXT2 : T_M4;
                                T_M4: begin
                                    n_run = 9'(v) + 9'd5;
                                    n_tok = T_DSEL;
                                end
                                T_MEXT2: n_tok = (v != 13'd0) ? T_LSEL : T_M8;
                                T_M8: begin
                                    n_run = 9'(v) + 9'd21;
                                    n_tok = T_DSEL;
                                end
                                T_DSEL:  n_tok = (v != 13'd0) ? T_D13 : T_D8;
                                T_D8: begin
                                    n_dist = 14'(v) + 14'd2;
                                    n_tok  = T_COPY;
                                end
                                T_D13: begin
                                    n_dist = 14'(v) + 14'd258;
                                    n_tok  = T_COPY;
                                end
                                default: n_tok = T_LSEL;
                            endcase
                        end
                    end
                end
            end
            S_COPY: begin
                // The source byte arrives from the read port this cycle. The
                // match distance is at least two, so the write never hits it.
                mem_we = 1'b1;
                mem_wd = r_rd;
                n_rem  = q;
                n_run  = run2;
                if (run2 == 9'd0) n_tok = T_LSEL;
                emit  = 1'b1;
                e_st  = ST_BYTE;
                e_b   = r_rd;
                e_pos = q[POS_W-1:0];
            end
            default: n_state = S_IDLE;
        endcase

        if (fin) begin
            emit    = 1'b1;
            n_hdr   = H_DONE;
            n_final = e_st;
        end
        if (emit) begin
            n_state          = S_IDLE;
            n_out_valid      = 1'b1;
            n_out.status     = e_st;
            n_out.data_byte  = e_b;
            n_out.position   = e_pos;
            n_out.last       = fin || (r_hdr == H_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[mem_wa] <= mem_wd;
        end
        r_rd <= r_hist[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hdr       <= H_LEN;
            r_tok       <= T_SKIP;
            r_buf       <= '0;
            r_bits_left <= '0;
            r_buf_full  <= 1'b0;
            r_chk       <= '0;
            r_rem       <= '0;
            r_len       <= '0;
            r_acc       <= '0;
            r_fbn       <= '0;
            r_run       <= '0;
            r_dist      <= '0;
            r_final     <= ST_WORD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hdr       <= n_hdr;
            r_tok       <= n_tok;
            r_buf       <= n_buf;
            r_bits_left <= n_bits_left;
            r_buf_full  <= n_buf_full;
            r_chk       <= n_chk;
            r_rem       <= n_rem;
            r_len       <= n_len;
            r_acc       <= n_acc;
            r_fbn       <= n_fbn;
            r_run       <= n_run;
            r_dist      <= n_dist;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_word <= n_word;
        r_out  <= n_out;
    end

    // A copy always completes in the cycle after its read is issued.
    a_copy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COPY |=> r_state == S_IDLE)
        else $error("copy did not complete");

    // A buffer that still counts bits must be marked full.
    a_bits_imply_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_left != 5'd0 |-> r_buf_full)
        else $error("bit count without a full buffer");

    // A new result only appears after the sequencer has worked on a beat.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_out_valid && !(r_out_valid && i_stall) |-> r_state != S_IDLE)
        else $error("result produced while idle");

    // Final beats carry a terminal status.
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.last |-> o_data.status >= ST_DONE)
        else $error("last beat with a non-terminal status");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ77 backward bit decoder core testbench
// Builds a well-formed compressed stream with a small encoder, runs a shadow
// decoder on every beat to predict the replies, drives the beats with random
// gaps and back-pressure, and checks every reply field by field.
// ----------------------------------------------------------------------------
module testbench;
    import lz77bd_pkg::*;

    // Token phases of the decoder's bit parser.
    typedef enum logic [3:0] {
        TP_SKIP, TP_LSEL, TP_LEXT, TP_L4, TP_LEXT2, TP_L8, TP_LIT, TP_MSEL,
        TP_MEXT, TP_M4, TP_MEXT2, TP_M8, TP_DSEL, TP_D8, TP_D13, TP_COPY
    } t_tok_phase;

    // Header phases: length word, checksum seed, data words, finished.
    localparam logic [1:0] HP_LEN  = 2'd0;
    localparam logic [1:0] HP_SEED = 2'd1;
    localparam logic [1:0] HP_DATA = 2'd2;
    localparam logic [1:0] HP_END  = 2'd3;

    // Ways the stream is made to end.
    localparam int END_CLEAN    = 0;
    localparam int END_BAD_SEED = 1;
    localparam int END_SHORT    = 2;
    localparam int END_OVERRUN  = 3;
    localparam int END_DISTANCE = 4;

    localparam int HIST_DEPTH = 1 << HIST_AW;
    localparam int PAUSE_AT   = 300;
    localparam int HOLD_AT    = 150;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_beat  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_beat o_data;

    lz77_backward_bit_decoder_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Shadow decoder state.
    logic [31:0] sh_bits;
    logic [4:0]  sh_bits_left;
    logic        sh_full;
    logic [31:0] sh_checksum;
    logic [17:0] sh_remaining;
    logic [17:0] sh_length;
    logic [1:0]  sh_header;
    t_tok_phase  sh_phase;
    logic [12:0] sh_acc;
    logic [3:0]  sh_need;
    logic [8:0]  sh_run;
    logic [13:0] sh_dist;
    logic [2:0]  sh_final;
    logic [7:0]  sh_hist [HIST_DEPTH];

    t_in_beat  beats_to_send [$];
    t_out_beat replies_due [$];
    int        sent_cnt;
    int        rcvd_cnt;
    int        fail_cnt;

    function automatic t_out_beat reply(logic [2:0] st, logic [7:0] b, logic [16:0] pos);
        t_out_beat r;
        r.status    = st;
        r.data_byte = b;
        r.position  = pos;
        r.last      = (st >= ST_DONE);
        return r;
    endfunction

    function automatic t_out_beat end_decode(logic [2:0] st);
        sh_header = HP_END;
        sh_final  = st;
        return reply(st, 8'd0, 17'd0);
    endfunction

    // Pulls an n-bit field from the bit buffer, MSB first. A field cut short by
    // an empty buffer resumes where it stopped once the next word arrives.
    function automatic bit pull_field(int n, output logic [12:0] v);
        if (sh_need == 0) begin
            sh_need = 4'(n);
            sh_acc  = '0;
        end
        while (sh_need != 0) begin
            if (!sh_full) return 1'b0;
            sh_acc  = {sh_acc[11:0], sh_bits[0]};
            sh_bits = sh_bits >> 1;
            if (sh_bits_left == 0) sh_full = 1'b0;
            else sh_bits_left--;
            sh_need--;
        end
        v = sh_acc;
        return 1'b1;
    endfunction

    function automatic t_out_beat decode_beat(logic [1:0] op, logic [31:0] w);
        logic [12:0] v;
        logic [17:0] q;
        logic [17:0] src;
        logic [7:0]  b;
        int          n;
        if (sh_header == HP_END) return reply(sh_final, 8'd0, 17'd0);
        if (op == OP_WORD) begin
            if (sh_header == HP_LEN) begin
                if (w > MAX_OUTPUT) return end_decode(ST_OVERRUN);
                sh_remaining = w[17:0];
                sh_length    = w[17:0];
                sh_header    = HP_SEED;
            end else if (sh_header == HP_SEED) begin
                sh_checksum = w;
                sh_header   = HP_DATA;
            end else if (!sh_full) begin
                sh_bits      = w;
                sh_checksum ^= w;
                sh_bits_left = 5'd31;
                sh_full      = 1'b1;
            end
            return reply(ST_WORD, 8'd0, 17'd0);
        end
        if (sh_header != HP_DATA)
            return (op == OP_END) ? end_decode(ST_INPUT) : reply(ST_NEED, 8'd0, 17'd0);
        forever begin
            if (sh_phase == TP_LSEL && sh_remaining == 0)
                return end_decode(sh_checksum != 0 ? ST_CHKSUM : ST_DONE);
            if (sh_phase == TP_COPY) begin
                if (sh_remaining == 0) return end_decode(ST_OVERRUN);
                q   = sh_remaining - 18'd1;
                src = q + 18'(sh_dist);
                if (src >= sh_length) return end_decode(ST_DIST);
                b = sh_hist[src % HIST_DEPTH];
                sh_hist[q % HIST_DEPTH] = b;
                sh_remaining = q;
                sh_run--;
                if (sh_run == 0) sh_phase = TP_LSEL;
                return reply(ST_BYTE, b, q[16:0]);
            end
            case (sh_phase)
                TP_LSEL, TP_MSEL: n = 2;
                TP_L4, TP_M4: n = 4;
                TP_L8, TP_M8, TP_LIT, TP_D8: n = 8;
                TP_D13: n = 13;
                default: n = 1;
            endcase
            if (!pull_field(n, v))
                return (op == OP_END) ? end_decode(ST_INPUT) : reply(ST_NEED, 8'd0, 17'd0);
            case (sh_phase)
                TP_SKIP: if (v != 0) sh_phase = TP_LSEL;
                TP_LSEL: begin
                    if (v < 3) begin
                        sh_run   = 9'(v) + 9'd1;
                        sh_phase = TP_LIT;
                    end else sh_phase = TP_LEXT;
                end
                TP_LEXT: sh_phase = v ? TP_LEXT2 : TP_L4;
                TP_L4: begin
                    sh_run   = 9'(v) + 9'd4;
                    sh_phase = TP_LIT;
                end
                TP_LEXT2: sh_phase = v ? TP_MSEL : TP_L8;
                TP_L8: begin
                    sh_run   = 9'(v) + 9'd20;
                    sh_phase = TP_LIT;
                end
                TP_LIT: begin
                    if (sh_remaining == 0) return end_decode(ST_OVERRUN);
                    q = sh_remaining - 18'd1;
                    sh_hist[q % HIST_DEPTH] = v[7:0];
                    sh_remaining = q;
                    sh_run--;
                    if (sh_run == 0) sh_phase = (sh_remaining == 0) ? TP_LSEL : TP_MSEL;
                    return reply(ST_BYTE, v[7:0], q[16:0]);
                end
                TP_MSEL: begin
                    if (v == 3) sh_phase = TP_MEXT;
                    else if (v == 0) begin
                        sh_run   = 9'd2;
                        sh_phase = TP_D8;
                    end else begin
                        sh_run   = 9'(v) + 9'd2;
                        sh_phase = TP_DSEL;
                    end
                end
                TP_MEXT: sh_phase = v ? TP_MEXT2 : TP_M4;
                TP_M4: begin
                    sh_run   = 9'(v) + 9'd5;
                    sh_phase = TP_DSEL;
                end
                TP_MEXT2: sh_phase = v ? TP_LSEL : TP_M8;
                TP_M8: begin
                    sh_run   = 9'(v) + 9'd21;
                    sh_phase = TP_DSEL;
                end
                TP_DSEL: sh_phase = v ? TP_D13 : TP_D8;
                TP_D8: begin
                    sh_dist  = 14'(v) + 14'd2;
                    sh_phase = TP_COPY;
                end
                TP_D13: begin
                    sh_dist  = 14'(v) + 14'd258;
                    sh_phase = TP_COPY;
                end
                default: sh_phase = TP_LSEL;
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stream encoder. Bits go into the stream in the order the decoder reads
    // them; each field is written MSB first.
    // ------------------------------------------------------------------------
    bit          stream_bits [$];
    logic [31:0] stream_words [$];

    function automatic void put_field(int val, int n);
        for (int i = n - 1; i >= 0; i--) stream_bits.push_back(val[i]);
    endfunction

    function automatic void put_lit_count(int c);
        if (c <= 3) put_field(c - 1, 2);
        else if (c <= 19) begin
            put_field(3, 2); put_field(0, 1); put_field(c - 4, 4);
        end else begin
            put_field(3, 2); put_field(1, 1); put_field(0, 1); put_field(c - 20, 8);
        end
    endfunction

    // A match of length 2 has no distance selector and only short distances.
    function automatic void put_match(int m, int d);
        if (m == 2) begin
            put_field(0, 2);
            put_field(d - 2, 8);
            return;
        end
        if (m <= 4) put_field(m - 2, 2);
        else if (m <= 20) begin
            put_field(3, 2); put_field(0, 1); put_field(m - 5, 4);
        end else begin
            put_field(3, 2); put_field(1, 1); put_field(0, 1); put_field(m - 21, 8);
        end
        if (d <= 257) begin
            put_field(0, 1); put_field(d - 2, 8);
        end else begin
            put_field(1, 1); put_field(d - 258, 13);
        end
    endfunction

    function automatic int pick_len(int hi);
        if (hi > 30 && $urandom_range(0, 9) == 0) return $urandom_range(20, hi > 275 ? 275 : hi);
        return $urandom_range(1, hi > 30 ? 30 : hi);
    endfunction

    function automatic void build_stream(int out_len, int end_mode);
        int rem;
        int done;
        int c;
        int m;
        int d;
        int dmax;
        rem  = out_len;
        done = 0;
        repeat ($urandom_range(0, 40)) put_field(0, 1);
        put_field(1, 1);
        while (rem > 0) begin
            // Literal run, or the escape straight to a match.
            if (done >= 2 && $urandom_range(0, 7) == 0) begin
                put_field(3, 2); put_field(1, 1); put_field(1, 1);
            end else begin
                c = pick_len(rem);
                put_lit_count(c);
                repeat (c) put_field($urandom_range(0, 255), 8);
                rem  -= c;
                done += c;
                if (rem == 0) break;
            end
            // Match, or the escape back to a literal run.
            if (done < 2 || $urandom_range(0, 7) == 0) begin
                put_field(3, 2); put_field(1, 1); put_field(1, 1);
                continue;
            end
            dmax = (done > 8449) ? 8449 : done;
            if (end_mode == END_OVERRUN && rem <= 20) begin
                put_match(rem + 1, $urandom_range(2, dmax > 257 ? 257 : dmax));
                return;
            end
            // The bad distance comes late so that most of the output is decoded.
            if (end_mode == END_DISTANCE && done > 40 && rem <= 80) begin
                put_match($urandom_range(3, 6), done + 1);
                return;
            end
            m = $urandom_range(2, rem > 30 ? 30 : rem);
            if (m == 2 || $urandom_range(0, 1) == 0) d = $urandom_range(2, dmax > 257 ? 257 : dmax);
            else d = $urandom_range(2, dmax);
            put_match(m, d);
            rem  -= m;
            done += m;
        end
    endfunction

    function automatic void queue_beat(logic [1:0] op, logic [31:0] w, output t_out_beat r);
        t_in_beat b;
        b.op = op;
        b.word = w;
        r = decode_beat(op, w);
        beats_to_send.push_back(b);
        replies_due.push_back(r);
    endfunction

    // Clock, reset and stimulus.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        t_out_beat   r;
        logic [31:0] seed;
        logic [1:0]  op;
        int          out_len;
        int          end_mode;
        int          wi;
        int          guard;
        i_rst_n = 1'b0;
        sh_bits = '0; sh_bits_left = '0; sh_full = 1'b0; sh_checksum = '0;
        sh_remaining = '0; sh_length = '0; sh_header = HP_LEN; sh_phase = TP_SKIP;
        sh_acc = '0; sh_need = '0; sh_run = '0; sh_dist = '0; sh_final = '0;
        for (int i = 0; i < HIST_DEPTH; i++) sh_hist[i] = '0;

        out_len  = $urandom_range(560, 680);
        end_mode = $urandom_range(END_CLEAN, END_DISTANCE);
        build_stream(out_len, end_mode);
        while (stream_bits.size() % 32 != 0) stream_bits.push_back($urandom_range(0, 1));
        seed = '0;
        for (int i = 0; i < stream_bits.size(); i += 32) begin
            logic [31:0] w;
            for (int j = 0; j < 32; j++) w[j] = stream_bits[i + j];
            stream_words.push_back(w);
            seed ^= w;
        end
        if (end_mode == END_BAD_SEED) seed ^= 32'h1 << $urandom_range(0, 31);
        if (end_mode == END_SHORT) void'(stream_words.pop_back());

        // Steps before the header ask for a word; then length and seed.
        queue_beat(OP_STEP, $urandom, r);
        queue_beat(2'd3, $urandom, r);
        queue_beat(OP_WORD, out_len, r);
        queue_beat(OP_STEP, $urandom, r);
        queue_beat(OP_WORD, seed, r);

        wi    = 0;
        guard = 0;
        while (!r.last && guard < 20000) begin
            guard++;
            if (r.status == ST_NEED && wi < stream_words.size() && $urandom_range(0, 5) != 0) begin
                queue_beat(OP_WORD, stream_words[wi], r);
                wi++;
            end else if (sh_full && $urandom_range(0, 24) == 0) begin
                // A word offered while the buffer still holds bits is dropped.
                queue_beat(OP_WORD, $urandom, r);
            end else begin
                if (wi >= stream_words.size() && r.status == ST_NEED) op = OP_END;
                else if (wi >= stream_words.size()) op = 2'($urandom_range(1, 3));
                else op = ($urandom_range(0, 3) == 0) ? 2'd3 : OP_STEP;
                queue_beat(op, $urandom, r);
            end
        end
        // After the end every beat repeats the final status.
        repeat (4) queue_beat(2'($urandom_range(0, 3)), $urandom, r);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (beats_to_send.size() == 0 && replies_due.size() == 0);
        repeat (60) @(posedge i_clk);
        if (fail_cnt == 0 && replies_due.size() == 0) begin
            $display("** lz77_backward_bit_decoder_core: PASSED **");
        end else begin
            $display("** lz77_backward_bit_decoder_core: FAILED **");
        end
        $finish;
    end

    // Time limit, far above the slowest legal run.
    initial begin
        #10ms;
        $display("** lz77_backward_bit_decoder_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver. Gaps are mostly short with a few long ones, and idling is turned
    // off for whole stretches. Once, the sender stops until every reply of
    // the beats sent so far has come back.
    // ------------------------------------------------------------------------
    int tx_gap;
    int tx_burst;
    bit paused_once;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_data      <= '0;
            tx_gap      <= 0;
            tx_burst    <= 0;
            sent_cnt    <= 0;
            paused_once <= 1'b0;
        end else begin
            if (i_valid && !o_stall) sent_cnt <= sent_cnt + 1;
            if (!i_valid || !o_stall) begin
                if (tx_gap > 0) begin
                    tx_gap  <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (!paused_once && sent_cnt + (i_valid ? 1 : 0) == PAUSE_AT
                             && rcvd_cnt < PAUSE_AT) begin
                    i_valid <= 1'b0;
                end else if (beats_to_send.size() != 0) begin
                    if (sent_cnt + (i_valid ? 1 : 0) == PAUSE_AT) paused_once <= 1'b1;
                    i_data   <= beats_to_send.pop_front();
                    i_valid  <= 1'b1;
                    tx_burst <= (tx_burst == 0) ? $urandom_range(10, 80) : tx_burst - 1;
                    if (tx_burst > 40 || $urandom_range(0, 9) < 6) tx_gap <= 0;
                    else if ($urandom_range(0, 9) < 8) tx_gap <= $urandom_range(1, 3);
                    else tx_gap <= $urandom_range(10, 40);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and receiver stall. The receiver holds off once for a long
    // stretch so that the core backs up and stalls its input.
    // ------------------------------------------------------------------------
    int  rx_hold;
    bit  held_once;

    always @(posedge i_clk) begin
        t_out_beat e;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            rcvd_cnt  <= 0;
            rx_hold   <= 0;
            held_once <= 1'b0;
            fail_cnt  <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                rcvd_cnt <= rcvd_cnt + 1;
                if (replies_due.size() == 0) begin
                    $error("reply with nothing expected: %p", o_data);
                    fail_cnt <= fail_cnt + 1;
                end else begin
                    e = replies_due.pop_front();
                    if (o_data !== e) begin
                        fail_cnt <= fail_cnt + 1;
                        if (o_data.status !== e.status)
                            $error("status: expected %0d, got %0d", e.status, o_data.status);
                        if (o_data.data_byte !== e.data_byte)
                            $error("data_byte: expected %0h, got %0h",
                                   e.data_byte, o_data.data_byte);
                        if (o_data.position !== e.position)
                            $error("position: expected %0d, got %0d",
                                   e.position, o_data.position);
                        if (o_data.last !== e.last)
                            $error("last: expected %0b, got %0b", e.last, o_data.last);
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                i_stall <= 1'b1;
            end else if (!held_once && rcvd_cnt >= HOLD_AT) begin
                held_once <= 1'b1;
                rx_hold   <= 400;
                i_stall   <= 1'b1;
            end else if (tx_burst > 40) begin
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 9) < 7) begin
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 9) < 8) begin
                i_stall <= 1'b1;
                rx_hold <= $urandom_range(0, 2);
            end else begin
                i_stall <= 1'b1;
                rx_hold <= $urandom_range(10, 40);
            end
        end
    end

endmodule

// File: sim.f
src/lz77bd_pkg.sv
src/lz77_backward_bit_decoder_core.sv
dv/testbench.sv
